/* hdl/lfu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, defaults and operation codes of the LFU key-value cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

    // field widths
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // default sizing
    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;

    // capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

endpackage
`default_nettype wire

/* hdl/lfu_key_value_cache.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_key_value_cache
// Fully associative key-value cache, least-frequently-used replacement with
// least-recently-used tie break, one sequential scan per request at nonzero capacity.
// ----------------------------------------------------------------------------
// A request (get or put) is taken when in_ready is high, then the block is
// busy: it scans every slot, one per cycle through the read ports of the
// key, data and use-count memories, checking for a match, counting valid
// slots, and tracking the first free slot and the eviction victim; a drain
// state lets the last read land, then the update state writes the update
// and loads the result. At capacity zero the scan and drain are skipped.
// The result waits in its output register, so the next request may be taken
// before it is read; only the update of that next request waits on it. No
// clearing pass is needed after reset: slot valid bits sit in flip-flops.
// Capacity is written through the cfg channel, which is always ready; the
// user must write it while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module lfu_key_value_cache #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             op,
    input  wire logic signed [lfu_pkg::KEY_W-1:0] lookup_key,
    input  wire logic signed [lfu_pkg::DATA_W-1:0] write_value,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  found,
    output logic signed [lfu_pkg::DATA_W-1:0]     read_value,
    // configuration channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lfu_pkg::CAP_W-1:0]        capacity_in_use
);
    import lfu_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    // control registers
    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   capacity_reg, capacity_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               cmp_vld_reg, cmp_vld_next;

    // request and scan registers
    logic              op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic              cap_zero_reg, cap_zero_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_slot_reg, hit_slot_next;
    logic [DATA_W-1:0] hit_data_reg, hit_data_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg, hit_cnt_next;
    logic [IDX_W-1:0]  hit_rank_reg, hit_rank_next;
    logic [CNT_W-1:0]  nvalid_reg, nvalid_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_slot_reg, free_slot_next;
    logic              vic_found_reg, vic_found_next;
    logic [IDX_W-1:0]  vic_slot_reg, vic_slot_next;
    logic [COUNT_BITS-1:0] vic_cnt_reg, vic_cnt_next;
    logic [IDX_W-1:0]  vic_rank_reg, vic_rank_next;
    logic [IDX_W-1:0]  rank_reg [ENTRIES];
    logic [IDX_W-1:0]  rank_next [ENTRIES];
    logic              found_reg, found_next;
    logic [DATA_W-1:0] read_value_reg, read_value_next;

    // slot memories
    logic [KEY_W-1:0]      key_mem [ENTRIES];
    logic [DATA_W-1:0]     data_mem [ENTRIES];
    logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
    logic [KEY_W-1:0]      rd_key_reg;
    logic [DATA_W-1:0]     rd_data_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;

    logic                  key_we, data_we, cnt_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_W-1:0]     data_wd;
    logic [COUNT_BITS-1:0] cnt_wd;

    // compare stage views
    logic             cmp_slot_valid;
    logic [IDX_W-1:0] cmp_rank;
    logic             upd_fire;
    logic             evict;
    logic [IDX_W-1:0] ins_slot;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;

    assign cmp_slot_valid = valid_reg[cmp_idx_reg];
    assign cmp_rank       = rank_reg[cmp_idx_reg];
    assign upd_fire       = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);
    assign evict          = (nvalid_reg >= cap_reg);
    assign ins_slot       = evict ? vic_slot_reg : free_slot_reg;

    // sequencer, scan trackers and update
    always_comb
    begin
        state_next      = state_reg;
        capacity_next   = capacity_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        cmp_vld_next    = 1'b0;
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        cap_next        = cap_reg;
        cap_zero_next   = cap_zero_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        hit_data_next   = hit_data_reg;
        hit_cnt_next    = hit_cnt_reg;
        hit_rank_next   = hit_rank_reg;
        nvalid_next     = nvalid_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        vic_found_next  = vic_found_reg;
        vic_slot_next   = vic_slot_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_rank_next   = vic_rank_reg;
        found_next      = found_reg;
        read_value_next = read_value_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        key_we  = 1'b0;
        data_we = 1'b0;
        cnt_we  = 1'b0;
        wr_addr = hit_slot_reg;
        data_wd = value_reg;
        cnt_wd  = COUNT_BITS'(1);

        // configuration write
        if (cfg_valid)
        begin
            capacity_next = capacity_in_use;
        end

        // result taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // compare one slot against the request
        if (cmp_vld_reg && cmp_slot_valid)
        begin
            nvalid_next = nvalid_reg + CNT_W'(1);
            if (rd_key_reg == key_reg)
            begin
                hit_next      = 1'b1;
                hit_slot_next = cmp_idx_reg;
                hit_data_next = rd_data_reg;
                hit_cnt_next  = rd_cnt_reg;
                hit_rank_next = cmp_rank;
            end
            if (!vic_found_reg || (rd_cnt_reg < vic_cnt_reg) ||
                ((rd_cnt_reg == vic_cnt_reg) && (cmp_rank > vic_rank_reg)))
            begin
                vic_found_next = 1'b1;
                vic_slot_next  = cmp_idx_reg;
                vic_cnt_next   = rd_cnt_reg;
                vic_rank_next  = cmp_rank;
            end
        end
        else if (cmp_vld_reg && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_slot_next  = cmp_idx_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = op;
                    key_next        = lookup_key;
                    value_next      = write_value;
                    scan_idx_next   = '0;
                    hit_next        = 1'b0;
                    nvalid_next     = '0;
                    free_found_next = 1'b0;
                    vic_found_next  = 1'b0;
                    if (32'(capacity_reg) >= 32'(ENTRIES))
                    begin
                        cap_next = CNT_W'(ENTRIES);
                    end
                    else
                    begin
                        cap_next = CNT_W'(capacity_reg);
                    end
                    cap_zero_next = (capacity_reg == '0);
                    state_next    = (capacity_reg == '0) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next  = 1'b1;
                cmp_idx_next  = scan_idx_reg;
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (upd_fire)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    found_next      = 1'b0;
                    read_value_next = '0;
                    if (cap_zero_reg)
                    begin
                        found_next = 1'b0;
                    end
                    else if (hit_reg)
                    begin
                        // touch the hit slot
                        found_next = 1'b1;
                        if (op_reg == OP_GET)
                        begin
                            read_value_next = hit_data_reg;
                        end
                        else
                        begin
                            data_we = 1'b1;
                        end
                        cnt_we  = 1'b1;
                        wr_addr = hit_slot_reg;
                        cnt_wd  = (hit_cnt_reg == '1) ? hit_cnt_reg
                                                      : hit_cnt_reg + COUNT_BITS'(1);
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                            begin
                                rank_next[i] = rank_reg[i] + IDX_W'(1);
                            end
                        end
                        rank_next[hit_slot_reg] = '0;
                    end
                    else if (op_reg == OP_PUT)
                    begin
                        // insert, evicting the victim when at capacity
                        key_we  = 1'b1;
                        data_we = 1'b1;
                        cnt_we  = 1'b1;
                        wr_addr = ins_slot;
                        cnt_wd  = COUNT_BITS'(1);
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (valid_reg[i])
                            begin
                                if (evict && (rank_reg[i] > vic_rank_reg))
                                begin
                                    rank_next[i] = rank_reg[i];
                                end
                                else
                                begin
                                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                                end
                            end
                        end
                        rank_next[ins_slot]  = '0;
                        valid_next[ins_slot] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            cmp_vld_reg   <= cmp_vld_next;
        end
    end

    // request, tracker and result payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        cap_reg        <= cap_next;
        cap_zero_reg   <= cap_zero_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        hit_slot_reg   <= hit_slot_next;
        hit_data_reg   <= hit_data_next;
        hit_cnt_reg    <= hit_cnt_next;
        hit_rank_reg   <= hit_rank_next;
        nvalid_reg     <= nvalid_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        vic_found_reg  <= vic_found_next;
        vic_slot_reg   <= vic_slot_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_rank_reg   <= vic_rank_next;
        found_reg      <= found_next;
        read_value_reg <= read_value_next;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_reg[i] <= rank_next[i];
        end
    end

    // key memory
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        rd_key_reg <= key_mem[scan_idx_reg];
    end

    // data memory
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[wr_addr] <= data_wd;
        end
        rd_data_reg <= data_mem[scan_idx_reg];
    end

    // use-count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[wr_addr] <= cnt_wd;
        end
        rd_cnt_reg <= cnt_mem[scan_idx_reg];
    end

endmodule
`default_nettype wire

/* hdl/lfu_cache_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_checker
// Port-level checks of the LFU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_cache_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             op,
    input wire logic signed [lfu_pkg::KEY_W-1:0] lookup_key,
    input wire logic signed [lfu_pkg::DATA_W-1:0] write_value,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic                             found,
    input wire logic signed [lfu_pkg::DATA_W-1:0] read_value,
    input wire logic                             cfg_ready
);
    import lfu_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(read_value))
        else $error("result changed while stalled");

    // a waiting request holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(op) && $stable(lookup_key) &&
                                  $stable(write_value))
        else $error("request changed while waiting");

    // a taken request keeps the block busy for its scan or update
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in flight");

    // a miss returns zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> read_value == '0)
        else $error("miss result carries a value");

    // cfg channel stays open for idle-time writes
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> cfg_ready)
        else $error("configuration blocked while idle");

endmodule

bind lfu_key_value_cache lfu_cache_checker u_lfu_cache_checker (.*);
`default_nettype wire

/* test/lfu_key_value_cache_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_key_value_cache_tb
// Self-checking bench for the LFU key-value cache. A directed table covers
// key and value extremes, hits, misses, updates, capacity zero, capacity
// above the slot count and capacity lowered under the stored entries. Random
// phases follow, each at its own capacity, with skewed key pools so that
// hits, frequency ranking and evictions all happen. Every result is checked
// against its typed table value or else an in-bench LFU/LRU predictor,
// under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module lfu_key_value_cache_tb;

    import lfu_pkg::*;

    localparam int SLOTS       = ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int DIR_ROWS    = 26;
    localparam int PHASES      = 11;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] value;
    } cache_result_t;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    // one directed row; val carries the capacity on configuration rows
    typedef struct packed {
        row_kind_t         kind;
        logic              r_op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] val;
        logic              typed;
        logic              exp_found;
        logic [DATA_W-1:0] exp_value;
    } stim_row_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic                     op          = OP_GET;
    logic signed [KEY_W-1:0]  lookup_key  = '0;
    logic signed [DATA_W-1:0] write_value = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         capacity_in_use = CAP_RESET;

    // predictor state
    logic              slot_valid [SLOTS];
    logic [KEY_W-1:0]  slot_key   [SLOTS];
    logic [DATA_W-1:0] slot_data  [SLOTS];
    logic [15:0]       slot_uses  [SLOTS];
    int unsigned       slot_age   [SLOTS];
    logic [CAP_W-1:0]  model_cap;

    cache_result_t pending_results [$];
    cache_result_t head_result;
    int            error_count = 0;
    int            cycle_count = 0;
    int            burst_left  = 0;
    int            ready_mode  = 0;
    int            ready_hold  = 0;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_REQ, OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{ROW_REQ, OP_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h7fff_ffff},
        '{ROW_REQ, OP_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff},
        // update of a present key
        '{ROW_REQ, OP_PUT, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'h5555_5555, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_PUT, 32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'h5555_5555, 32'h0000_0000, 1'b1, 1'b1, 32'haaaa_aaaa},
        // capacity lowered under the four stored entries
        '{ROW_CFG, OP_GET, 32'h0000_0000, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_PUT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        // capacity zero: nothing stored, nothing found
        '{ROW_CFG, OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_PUT, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        // capacity above the slot count, then one
        '{ROW_CFG, OP_GET, 32'h0000_0000, 32'h0000_001f, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CFG, OP_GET, 32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_PUT, 32'h0000_0002, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_REQ, OP_GET, 32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_CFG, OP_GET, 32'h0000_0000, 32'h0000_0010, 1'b0, 1'b0, 32'h0000_0000}
    };

    logic [CAP_W-1:0] cap_plan [PHASES] = '{
        5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd2, 5'd12, 5'd16
    };

    lfu_key_value_cache u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .lookup_key      (lookup_key),
        .write_value     (write_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .read_value      (read_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .capacity_in_use (capacity_in_use)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lfu_key_value_cache verification failed");
            $finish;
        end
    end

    // receiver: stretches of always ready, random ready, or full stall
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            ready_hold <= $urandom_range(1, 24);
        end
        else
        begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= 1'b0;
        endcase
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch %0s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, found/read_value", {31'b0, found},
                                read_value);
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (found !== head_result.found)
                    report_mismatch("found", {31'b0, found}, {31'b0, head_result.found});
                if (read_value !== head_result.value)
                    report_mismatch("read_value", read_value, head_result.value);
            end
        end
    end

    // hit on slot s: raise its count and make it the most recent
    function automatic void refresh_slot(input int s);
        int unsigned cut;
        cut = slot_age[s];
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && i != s && slot_age[i] < cut)
                slot_age[i]++;
        slot_age[s] = 0;
        if (slot_uses[s] != 16'hffff)
            slot_uses[s]++;
    endfunction

    // lookup/insert with LFU eviction, LRU among equal counts
    function automatic cache_result_t predict_access(input logic r_op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [DATA_W-1:0] val);
        cache_result_t res;
        int            eff_cap;
        int            hit;
        int            used;
        int            free_idx;
        int            victim;
        int unsigned   cut;
        res     = '0;
        eff_cap = (model_cap > SLOTS) ? SLOTS : model_cap;
        if (eff_cap == 0)
            return res;
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && slot_valid[i] && slot_key[i] == key)
                hit = i;
        if (hit >= 0)
        begin
            if (r_op == OP_PUT)
                slot_data[hit] = val;
            else
                res.value = slot_data[hit];
            res.found = 1'b1;
            refresh_slot(hit);
            return res;
        end
        if (r_op == OP_GET)
            return res;

        // miss on a put: count residents, find the lowest free slot
        used     = 0;
        free_idx = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_valid[i])
                used++;
            else if (free_idx < 0)
                free_idx = i;
        end

        // full: drop the least used, oldest among equals
        if (used >= eff_cap)
        begin
            victim = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_valid[i])
                begin
                    if (victim < 0)
                        victim = i;
                    else if (slot_uses[i] < slot_uses[victim])
                        victim = i;
                    else if (slot_uses[i] == slot_uses[victim] &&
                             slot_age[i] > slot_age[victim])
                        victim = i;
                end
            end
            if (victim >= 0)
            begin
                cut = slot_age[victim];
                slot_valid[victim] = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i] && slot_age[i] > cut)
                        slot_age[i]--;
                free_idx = victim;
            end
        end
        if (free_idx < 0)
            return res;

        // insert as most recent with count 1
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i])
                slot_age[i]++;
        slot_valid[free_idx] = 1'b1;
        slot_key[free_idx]   = key;
        slot_data[free_idx]  = val;
        slot_uses[free_idx]  = 16'd1;
        slot_age[free_idx]   = 0;
        return res;
    endfunction

    // hold off new requests until every result is back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_valid       = 1'b1;
        capacity_in_use = cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_cap = cap;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one request, sent in bursts with random gaps between them
    task automatic send_request(input logic r_op, input logic [KEY_W-1:0] key,
                                input logic [DATA_W-1:0] val, input logic typed,
                                input cache_result_t typed_res);
        cache_result_t res;
        int            gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 25 : 4);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid    = 1'b1;
        op          = r_op;
        lookup_key  = key;
        write_value = val;
        do
            @(posedge clk);
        while (!in_ready);
        res = predict_access(r_op, key, val);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    initial
    begin
        logic [KEY_W-1:0]  key_pool [POOL_SIZE];
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] val;
        logic              r_op;
        int                phase_items;
        int                eff_cap;
        int                active;
        int                idx;
        int                pick;

        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_data[i]  = '0;
            slot_uses[i]  = '0;
            slot_age[i]   = 0;
        end
        model_cap = CAP_RESET;

        // hold reset, then release it
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_capacity(directed_rows[r].val[CAP_W-1:0]);
            else
                send_request(directed_rows[r].r_op, directed_rows[r].key,
                             directed_rows[r].val, directed_rows[r].typed,
                             {directed_rows[r].exp_found, directed_rows[r].exp_value});
        end

        // random phases, one capacity each
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(cap_plan[p]);
            eff_cap     = (cap_plan[p] > SLOTS) ? SLOTS : cap_plan[p];
            phase_items = (eff_cap == 0) ? 40 : 162;
            active      = (eff_cap + 4 > POOL_SIZE) ? POOL_SIZE : eff_cap + 4;
            if (active < 6)
                active = 6;

            // key pool: small numbers, negatives, extremes and wide random keys
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                case ($urandom_range(0, 4))
                    0:       key_pool[i] = i;
                    1:       key_pool[i] = -i;
                    2:       key_pool[i] = (i[0]) ? 32'h8000_0000 ^ i : 32'h7fff_ffff ^ i;
                    default: key_pool[i] = $urandom;
                endcase
            end

            for (int n = 0; n < phase_items; n++)
            begin
                // one mid-phase pause until the cache has answered everything
                if (p == 2 && n == phase_items / 2)
                    wait_drained();

                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    key = $urandom;
                end
                else
                begin
                    // skew toward low pool indices so use counts spread out
                    idx = $urandom_range(0, active - 1);
                    if (pick < 60)
                        idx = (idx < $urandom_range(0, active - 1)) ?
                              idx : $urandom_range(0, idx);
                    key = key_pool[idx];
                end

                case ($urandom_range(0, 15))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7fff_ffff;
                    2:       val = 32'hffff_ffff;
                    3:       val = 32'h0000_0000;
                    default: val = $urandom;
                endcase

                r_op = ($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET;
                send_request(r_op, key, val, 1'b0, '0);
            end
        end

        // drain, then let any stray result show up
        wait_drained();
        repeat (4 * SLOTS) @(posedge clk);

        if (error_count == 0)
            $display("lfu_key_value_cache verification clean");
        else
            $display("lfu_key_value_cache verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/lfu_pkg.sv
hdl/lfu_key_value_cache.sv
hdl/lfu_cache_checker.sv
test/lfu_key_value_cache_tb.sv
